>>> src/m4ta_pkg.sv
// ============================================================================
// m4ta_pkg
// Shared types, constants and a helper function for the 4x4 transform
// accumulator: action codes, pipeline tags and memory write beats.
// ============================================================================
package m4ta_pkg;

    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    typedef enum logic [2:0] {
        ACT_IDENT = 3'd0,
        ACT_WRITE = 3'd1,
        ACT_MUL   = 3'd2,
        ACT_TRANS = 3'd3,
        ACT_SCALE = 3'd4,
        ACT_READ  = 3'd5
    } act_t;

    // Tag that travels with one multiply-accumulate step.
    typedef struct packed {
        logic       vld;
        logic       first;
        logic       last;
        logic [1:0] k;
        logic [1:0] col;
    } mac_tag_t;

    // Finished element leaving the multiply-accumulate pipeline.
    typedef struct packed {
        logic        vld;
        logic [1:0]  col;
        logic        sat;
        logic [31:0] value;
    } mac_wr_t;

    // One write beat into a matrix memory.
    typedef struct packed {
        logic        we;
        logic [3:0]  addr;
        logic [31:0] data;
    } mem_wr_t;

    // Element [k][j] of the translation or scale matrix.
    function automatic logic [31:0] rhs_elem(
        input logic [2:0]  act,
        input logic [1:0]  k,
        input logic [1:0]  j,
        input logic [31:0] x,
        input logic [31:0] y,
        input logic [31:0] z
    );
        logic [31:0] v;
        logic [31:0] xyz;
        begin
            case (k)
                2'd0:    xyz = x;
                2'd1:    xyz = y;
                2'd2:    xyz = z;
                default: xyz = Q_ONE;
            endcase
            v = 32'd0;
            if (act == ACT_TRANS) begin
                if (k == j) begin
                    v = Q_ONE;
                end else if (j == 2'd3) begin
                    v = xyz;
                end
            end else begin
                if (k == j) begin
                    v = xyz;
                end
            end
            return v;
        end
    endfunction

endpackage

>>> src/m4ta_store.sv
// ============================================================================
// m4ta_store
// Current and operand matrix memories, one write and one registered read
// each. Per-entry valid bits make unwritten entries read as identity.
// ============================================================================
module m4ta_store (
    input  logic              clk,
    input  logic              rst_n,
    input  m4ta_pkg::mem_wr_t c_wr,
    input  logic [3:0]        c_raddr,
    output logic [31:0]       c_rdata,
    input  m4ta_pkg::mem_wr_t m_wr,
    input  logic [3:0]        m_raddr,
    output logic [31:0]       m_rdata
);
    import m4ta_pkg::*;

    logic [31:0] c_mem [16];
    logic [31:0] m_mem [16];
    logic [15:0] c_vld_reg;
    logic [15:0] m_vld_reg;
    logic [31:0] c_raw_reg;
    logic [31:0] m_raw_reg;
    logic        c_hit_reg;
    logic        m_hit_reg;
    logic        c_diag_reg;
    logic        m_diag_reg;

    always_ff @(posedge clk)
    begin
        if (c_wr.we)
        begin
            c_mem[c_wr.addr] <= c_wr.data;
        end
        if (m_wr.we)
        begin
            m_mem[m_wr.addr] <= m_wr.data;
        end
        c_raw_reg <= c_mem[c_raddr];
        m_raw_reg <= m_mem[m_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg  <= '0;
            m_vld_reg  <= '0;
            c_hit_reg  <= 1'b0;
            m_hit_reg  <= 1'b0;
            c_diag_reg <= 1'b0;
            m_diag_reg <= 1'b0;
        end
        else
        begin
            if (c_wr.we)
            begin
                c_vld_reg[c_wr.addr] <= 1'b1;
            end
            if (m_wr.we)
            begin
                m_vld_reg[m_wr.addr] <= 1'b1;
            end
            c_hit_reg  <= c_vld_reg[c_raddr];
            m_hit_reg  <= m_vld_reg[m_raddr];
            c_diag_reg <= (c_raddr[3:2] == c_raddr[1:0]);
            m_diag_reg <= (m_raddr[3:2] == m_raddr[1:0]);
        end
    end

    assign c_rdata = c_hit_reg ? c_raw_reg : (c_diag_reg ? Q_ONE : 32'd0);
    assign m_rdata = m_hit_reg ? m_raw_reg : (m_diag_reg ? Q_ONE : 32'd0);

endmodule

>>> src/m4ta_mac.sv
// ============================================================================
// m4ta_mac
// Four-stage multiply-accumulate pipeline: product, truncation toward zero,
// row-by-column accumulation, and saturation to 32 bits.
// ============================================================================
module m4ta_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  m4ta_pkg::mac_tag_t tag_in,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output m4ta_pkg::mac_wr_t  wr
);
    import m4ta_pkg::*;

    localparam logic signed [49:0] SUM_MAX = 50'sd2147483647;
    localparam logic signed [49:0] SUM_MIN = -50'sd2147483648;

    mac_tag_t           tag2_reg;
    mac_tag_t           tag3_reg;
    mac_tag_t           tag4_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] biased;
    logic signed [47:0] trunc_reg;
    logic signed [49:0] acc_reg;
    logic signed [49:0] acc_next;
    mac_wr_t            wr_reg;
    mac_wr_t            wr_next;

    // Adding 2^16-1 to a negative product makes the shift round toward zero.
    assign biased   = prod_reg + (prod_reg[63] ? 64'sd65535 : 64'sd0);
    assign acc_next = (tag3_reg.first ? 50'sd0 : acc_reg)
                      + {{2{trunc_reg[47]}}, trunc_reg};

    always_comb
    begin
        wr_next     = '0;
        wr_next.vld = tag4_reg.vld && tag4_reg.last;
        wr_next.col = tag4_reg.col;
        if (acc_reg > SUM_MAX)
        begin
            wr_next.sat   = 1'b1;
            wr_next.value = 32'h7FFF_FFFF;
        end
        else if (acc_reg < SUM_MIN)
        begin
            wr_next.sat   = 1'b1;
            wr_next.value = 32'h8000_0000;
        end
        else
        begin
            wr_next.value = acc_reg[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= a * b;
        trunc_reg <= biased[63:16];
        if (tag3_reg.vld)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            wr_reg   <= '0;
        end
        else
        begin
            tag2_reg <= tag_in;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            wr_reg   <= wr_next;
        end
    end

    assign wr = wr_reg;

endmodule

>>> src/mat4_transform_accumulator_unit.sv
// ============================================================================
// mat4_transform_accumulator_unit
// 4x4 Q16.16 transform accumulator: identity load, operand write, multiply,
// translate, scale and element read over two 16-entry matrix memories.
// ============================================================================
// An action is taken when start is high and busy is low; its single result
// beat appears on done with read_value and saturated, and cannot be held off.
// Operand write and unused action codes report in the cycle after start and
// leave busy low. Read passes through the registered memory read and then
// the read state; identity load makes one memory write per element. For
// multiply, translate and scale, each of the four rows is loaded through the
// single read port, then sixteen products go through one shared
// multiply-accumulate pipeline, which drains before the next row is loaded.
module mat4_transform_accumulator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [1:0]  row,
    input  logic [1:0]  col,
    input  logic [31:0] operand_x,
    input  logic [31:0] operand_y,
    input  logic [31:0] operand_z,
    output logic        done,
    output logic [31:0] read_value,
    output logic        saturated
);
    import m4ta_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_FILL   = 7'b0000010,
        ST_READ   = 7'b0000100,
        ST_LOAD   = 7'b0001000,
        ST_MAC    = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  act_reg, act_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] y_reg, y_next;
    logic [31:0] z_reg, z_next;
    logic [1:0]  row_reg, row_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        sat_reg, sat_next;
    logic        ld_vld_reg, ld_vld_next;
    logic [1:0]  ld_idx_reg, ld_idx_next;
    logic [31:0] rowbuf_reg [4];
    mac_tag_t    tag_s1_reg, tag_s0;
    logic [31:0] gen_s1_reg;
    logic        done_reg, done_next;
    logic [31:0] read_value_reg, read_value_next;
    logic        saturated_reg, saturated_next;

    mem_wr_t     c_wr, m_wr;
    logic [3:0]  c_raddr, m_raddr;
    logic [31:0] c_rdata, m_rdata;
    logic [31:0] mac_b;
    mac_wr_t     mac_wr;

    m4ta_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .c_wr    (c_wr),
        .c_raddr (c_raddr),
        .c_rdata (c_rdata),
        .m_wr    (m_wr),
        .m_raddr (m_raddr),
        .m_rdata (m_rdata)
    );

    assign mac_b = (act_reg == ACT_MUL) ? m_rdata : gen_s1_reg;

    m4ta_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag_in (tag_s1_reg),
        .a      (rowbuf_reg[tag_s1_reg.k]),
        .b      (mac_b),
        .wr     (mac_wr)
    );

    // Operand elements are walked column by column, k fastest.
    assign m_raddr = {cnt_reg[1:0], cnt_reg[3:2]};
    assign c_raddr = (state_reg == ST_IDLE) ? {row, col} : {row_reg, cnt_reg[1:0]};

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        row_next        = row_reg;
        cnt_next        = cnt_reg;
        sat_next        = sat_reg;
        ld_vld_next     = 1'b0;
        ld_idx_next     = ld_idx_reg;
        tag_s0          = '0;
        done_next       = 1'b0;
        read_value_next = 32'd0;
        saturated_next  = 1'b0;
        c_wr            = '0;
        m_wr            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next = action;
                    x_next   = operand_x;
                    y_next   = operand_y;
                    z_next   = operand_z;
                    cnt_next = 4'd0;
                    row_next = 2'd0;
                    sat_next = 1'b0;
                    case (action)
                        ACT_IDENT: state_next = ST_FILL;
                        ACT_WRITE:
                        begin
                            m_wr.we   = 1'b1;
                            m_wr.addr = {row, col};
                            m_wr.data = operand_x;
                            done_next = 1'b1;
                        end
                        ACT_MUL, ACT_TRANS, ACT_SCALE: state_next = ST_LOAD;
                        ACT_READ:  state_next = ST_READ;
                        default:   done_next  = 1'b1;
                    endcase
                end
            end
            ST_FILL:
            begin
                c_wr.we   = 1'b1;
                c_wr.addr = cnt_reg;
                c_wr.data = (cnt_reg[3:2] == cnt_reg[1:0]) ? x_reg : 32'd0;
                cnt_next  = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                done_next       = 1'b1;
                read_value_next = c_rdata;
                state_next      = ST_IDLE;
            end
            ST_LOAD:
            begin
                ld_vld_next = 1'b1;
                ld_idx_next = cnt_reg[1:0];
                if (cnt_reg[1:0] == 2'd3)
                begin
                    cnt_next   = 4'd0;
                    state_next = ST_MAC;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_MAC:
            begin
                tag_s0.vld   = 1'b1;
                tag_s0.k     = cnt_reg[1:0];
                tag_s0.col   = cnt_reg[3:2];
                tag_s0.first = (cnt_reg[1:0] == 2'd0);
                tag_s0.last  = (cnt_reg[1:0] == 2'd3);
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The next row is loaded only once this row is fully written.
                if (mac_wr.vld && mac_wr.col == 2'd3)
                begin
                    cnt_next = 4'd0;
                    if (row_reg == 2'd3)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        row_next   = row_reg + 2'd1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_FINISH:
            begin
                done_next      = 1'b1;
                saturated_next = sat_reg;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (mac_wr.vld)
        begin
            c_wr.we   = 1'b1;
            c_wr.addr = {row_reg, mac_wr.col};
            c_wr.data = mac_wr.value;
            sat_next  = sat_reg | mac_wr.sat;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        gen_s1_reg <= rhs_elem(act_reg, cnt_reg[1:0], cnt_reg[3:2], x_reg, y_reg, z_reg);
        if (ld_vld_reg)
        begin
            rowbuf_reg[ld_idx_reg] <= c_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            row_reg        <= 2'd0;
            cnt_reg        <= 4'd0;
            sat_reg        <= 1'b0;
            ld_vld_reg     <= 1'b0;
            ld_idx_reg     <= 2'd0;
            tag_s1_reg     <= '0;
            done_reg       <= 1'b0;
            read_value_reg <= 32'd0;
            saturated_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            cnt_reg        <= cnt_next;
            sat_reg        <= sat_next;
            ld_vld_reg     <= ld_vld_next;
            ld_idx_reg     <= ld_idx_next;
            tag_s1_reg     <= tag_s0;
            done_reg       <= done_next;
            read_value_reg <= read_value_next;
            saturated_reg  <= saturated_next;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign saturated  = saturated_reg;

`ifndef SYNTHESIS
    // Finished elements only come back while a product is being formed.
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_wr.vld |-> (state_reg == ST_MAC || state_reg == ST_DRAIN))
        else $error("element write-back outside a multiply");

    // The pipeline is empty whenever the block can take a new beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !tag_s1_reg.vld)
        else $error("multiply pipeline still busy while idle");

    // Saturation is only reported at the end of a multiply.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> $past(state_reg == ST_FINISH))
        else $error("saturation reported for a non-multiply action");

    // A nonzero read value only follows a read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && read_value != 32'd0) |-> $past(state_reg == ST_READ))
        else $error("nonzero read value outside a read");
`endif

endmodule

>>> tb/sv/tb_mat4_transform_accumulator_unit.sv
// ============================================================================
// tb_mat4_transform_accumulator_unit
// Self-checking testbench for the 4x4 Q16.16 transform accumulator. A queue
// of pending commands feeds a clocked driver. The driver predicts the result
// of every accepted command from its own copy of both matrices. A clocked
// monitor checks each done beat against the oldest predicted result.
// ============================================================================
module tb_mat4_transform_accumulator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import m4ta_pkg::*;

    typedef logic signed [31:0] q_t;

    // The block has no names for these codes. It must ignore them.
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam int TAIL_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 4000;

    typedef struct {
        logic [2:0] action;
        logic [1:0] row;
        logic [1:0] col;
        q_t         x;
        q_t         y;
        q_t         z;
        bit         drain;
        int         idle_pct;
    } cmd_t;

    typedef struct {
        logic [31:0] read_value;
        logic        saturated;
    } xform_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  action = '0;
    logic [1:0]  row = '0;
    logic [1:0]  col = '0;
    logic [31:0] operand_x = '0;
    logic [31:0] operand_y = '0;
    logic [31:0] operand_z = '0;
    logic        busy;
    logic        done;
    logic [31:0] read_value;
    logic        saturated;

    cmd_t          pending_cmds[$];
    xform_result_t expected_results[$];
    cmd_t          issued_cmd;
    q_t            cur_m[16];
    q_t            opd_m[16];
    int            errors = 0;

    mat4_transform_accumulator_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .row        (row),
        .col        (col),
        .operand_x  (operand_x),
        .operand_y  (operand_y),
        .operand_z  (operand_z),
        .done       (done),
        .read_value (read_value),
        .saturated  (saturated)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void load_diagonal(ref q_t m[16], input q_t a, input q_t b,
                                          input q_t c, input q_t d);
        for (int i = 0; i < 16; i++)
        begin
            m[i] = '0;
        end
        m[0]  = a;
        m[5]  = b;
        m[10] = c;
        m[15] = d;
    endfunction

    // Replaces the current matrix by current * rhs. Each product is truncated
    // toward zero before the row sum, and the sum saturates to 32 bits.
    function automatic bit post_multiply(input q_t rhs[16]);
        q_t     res[16];
        bit     sat;
        longint acc;
        longint prod;
        sat = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                begin
                    prod = longint'(cur_m[i*4+k]) * longint'(rhs[k*4+j]);
                    acc += prod / 65536;
                end
                if (acc > longint'(32'sh7FFF_FFFF))
                begin
                    acc = longint'(32'sh7FFF_FFFF);
                    sat = 1'b1;
                end
                else if (acc < -longint'(64'sh8000_0000))
                begin
                    acc = -longint'(64'sh8000_0000);
                    sat = 1'b1;
                end
                res[i*4+j] = q_t'(acc);
            end
        end
        cur_m = res;
        return sat;
    endfunction

    function automatic xform_result_t apply_command(input cmd_t c);
        xform_result_t r;
        q_t            tmp[16];
        r.read_value = '0;
        r.saturated  = 1'b0;
        case (c.action)
            ACT_IDENT: load_diagonal(cur_m, c.x, c.x, c.x, c.x);
            ACT_WRITE: opd_m[{c.row, c.col}] = c.x;
            ACT_MUL:   r.saturated = post_multiply(opd_m);
            ACT_TRANS:
            begin
                load_diagonal(tmp, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
                tmp[3]  = c.x;
                tmp[7]  = c.y;
                tmp[11] = c.z;
                r.saturated = post_multiply(tmp);
            end
            ACT_SCALE:
            begin
                load_diagonal(tmp, c.x, c.y, c.z, Q_ONE);
                r.saturated = post_multiply(tmp);
            end
            ACT_READ:  r.read_value = cur_m[{c.row, c.col}];
            default:   ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic q_t rand_q();
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 35)
        begin
            v = int'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
        end
        else if (sel < 55)
        begin
            v = int'($urandom_range(32'h0000_4000)) - 32'h0000_2000 + 32'h0001_0000;
            if ($urandom_range(1))
            begin
                v = -v;
            end
        end
        else if (sel < 75)
        begin
            v = int'($urandom);
        end
        else if (sel < 85)
        begin
            case ($urandom_range(4))
                0:       v = 32'h7FFF_FFFF;
                1:       v = 32'h8000_0000;
                2:       v = 0;
                3:       v = Q_ONE;
                default: v = -int'(Q_ONE);
            endcase
        end
        else
        begin
            v = int'($urandom_range(32'h0002_0000)) - 32'h0001_0000;
        end
        return q_t'(v);
    endfunction

    function automatic logic [2:0] rand_action();
        int w;
        w = $urandom_range(99);
        if (w < 10)      return ACT_IDENT;
        else if (w < 34) return ACT_WRITE;
        else if (w < 46) return ACT_MUL;
        else if (w < 58) return ACT_TRANS;
        else if (w < 70) return ACT_SCALE;
        else if (w < 96) return ACT_READ;
        else if (w < 98) return ACT_SPARE_LO;
        else             return ACT_SPARE_HI;
    endfunction

    function automatic void queue_cmd(input logic [2:0] a, input logic [1:0] r,
                                      input logic [1:0] c, input q_t x, input q_t y,
                                      input q_t z, input bit drain, input int idle_pct);
        cmd_t cmd;
        cmd.action   = a;
        cmd.row      = r;
        cmd.col      = c;
        cmd.x        = x;
        cmd.y        = y;
        cmd.z        = z;
        cmd.drain    = drain;
        cmd.idle_pct = idle_pct;
        pending_cmds.push_back(cmd);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: a command stays on the ports until a beat is taken (start high,
    // busy low). A command marked drain is not offered before every result
    // in flight has come back.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_proc
        cmd_t nxt;
        bit   holding;
        if (rst_n)
        begin
            holding = 1'b0;
            if (start)
            begin
                if (!busy)
                begin
                    expected_results.push_back(apply_command(issued_cmd));
                end
                else
                begin
                    holding = 1'b1;
                end
            end
            if (!holding)
            begin
                if (pending_cmds.size() == 0)
                begin
                    start <= 1'b0;
                end
                else
                begin
                    nxt = pending_cmds[0];
                    if ((nxt.drain && expected_results.size() != 0) ||
                        ($urandom_range(99) < nxt.idle_pct))
                    begin
                        start <= 1'b0;
                    end
                    else
                    begin
                        void'(pending_cmds.pop_front());
                        issued_cmd <= nxt;
                        start      <= 1'b1;
                        action     <= nxt.action;
                        row        <= nxt.row;
                        col        <= nxt.col;
                        operand_x  <= nxt.x;
                        operand_y  <= nxt.y;
                        operand_z  <= nxt.z;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_proc
        xform_result_t e;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat: read_value %h saturated %b",
                       read_value, saturated);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (read_value !== e.read_value)
                begin
                    $error("read_value: expected %h, actual %h", e.read_value, read_value);
                    errors++;
                end
                if (saturated !== e.saturated)
                begin
                    $error("saturated: expected %b, actual %b", e.saturated, saturated);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int   pct;
        int   waited;
        q_t   ident_x;
        load_diagonal(cur_m, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        load_diagonal(opd_m, Q_ONE, Q_ONE, Q_ONE, Q_ONE);

        // Reset contents, then the unused codes with every field bit set.
        queue_cmd(ACT_READ, 2'd0, 2'd0, 0, 0, 0, 0, 30);
        queue_cmd(ACT_READ, 2'd3, 2'd3, 0, 0, 0, 0, 30);
        queue_cmd(ACT_READ, 2'd1, 2'd2, 0, 0, 0, 0, 30);
        queue_cmd(ACT_MUL, 2'd0, 2'd0, 0, 0, 0, 0, 30);
        queue_cmd(ACT_SPARE_LO, 2'd3, 2'd3, -1, -1, -1, 0, 30);
        queue_cmd(ACT_SPARE_HI, 2'd3, 2'd3, -1, -1, -1, 0, 30);
        // Positive and negative saturation through the operand matrix and through scale.
        queue_cmd(ACT_WRITE, 2'd0, 2'd0, 32'sh7FFF_FFFF, 0, 0, 0, 30);
        queue_cmd(ACT_WRITE, 2'd3, 2'd3, 32'sh8000_0000, 0, 0, 0, 30);
        queue_cmd(ACT_IDENT, 2'd0, 2'd0, 32'sh7FFF_FFFF, 0, 0, 0, 30);
        queue_cmd(ACT_MUL, 2'd0, 2'd0, 0, 0, 0, 0, 30);
        queue_cmd(ACT_READ, 2'd0, 2'd0, 0, 0, 0, 0, 30);
        queue_cmd(ACT_READ, 2'd3, 2'd3, 0, 0, 0, 0, 30);
        queue_cmd(ACT_IDENT, 2'd0, 2'd0, 32'sh8000_0000, 0, 0, 0, 30);
        queue_cmd(ACT_SCALE, 2'd0, 2'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 30);
        queue_cmd(ACT_READ, 2'd0, 2'd0, 0, 0, 0, 0, 30);
        queue_cmd(ACT_READ, 2'd1, 2'd1, 0, 0, 0, 0, 30);
        // Translation with extreme offsets.
        queue_cmd(ACT_IDENT, 2'd0, 2'd0, Q_ONE, 0, 0, 0, 30);
        queue_cmd(ACT_TRANS, 2'd0, 2'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, Q_ONE, 0, 30);
        queue_cmd(ACT_READ, 2'd0, 2'd3, 0, 0, 0, 0, 30);
        queue_cmd(ACT_READ, 2'd1, 2'd3, 0, 0, 0, 0, 30);
        // A negative product smaller than one LSB must truncate to zero.
        queue_cmd(ACT_IDENT, 2'd0, 2'd0, -1, 0, 0, 0, 30);
        queue_cmd(ACT_SCALE, 2'd0, 2'd0, 32'sh0000_8000, -32'sh0001_8000, 3, 0, 30);
        queue_cmd(ACT_READ, 2'd0, 2'd0, 0, 0, 0, 0, 30);
        queue_cmd(ACT_READ, 2'd1, 2'd1, 0, 0, 0, 0, 30);
        queue_cmd(ACT_READ, 2'd2, 2'd2, 0, 0, 0, 0, 30);

        for (int i = 0; i < 650; i++)
        begin
            pct = (i < 217) ? 30 : (i < 434) ? 48 : 0;
            ident_x = $urandom_range(1) ? q_t'(Q_ONE) : rand_q();
            if (i % 130 == 65)
            begin
                queue_cmd(ACT_READ, 2'($urandom), 2'($urandom), rand_q(), rand_q(),
                          rand_q(), 1, pct);
            end
            else
            begin
                queue_cmd(rand_action(), 2'($urandom), 2'($urandom),
                          $urandom_range(3) == 0 ? ident_x : rand_q(), rand_q(),
                          rand_q(), 0, pct);
            end
            // Identity loads use the chosen diagonal value.
            if (pending_cmds[$].action == ACT_IDENT)
            begin
                pending_cmds[$].x = ident_x;
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start)
        begin
            @(posedge clk);
        end
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0)
        begin
            $display("tb_mat4_transform_accumulator_unit passed");
        end
        else
        begin
            $display("tb_mat4_transform_accumulator_unit failed");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_mat4_transform_accumulator_unit failed");
        $finish;
    end

endmodule
